// File: rtl/typed_stack_machine_execute_defines.svh
// Assertion macros used by the checker file tsm_checker.sv.
// No dependencies.
`ifndef TYPED_STACK_MACHINE_EXECUTE_DEFINES_SVH
`define TYPED_STACK_MACHINE_EXECUTE_DEFINES_SVH

// Plain implication check, sampled on clk, off while rst_n is low.
`define TSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define TSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tsm_pkg.sv
// Shared types, codes and helper functions of the typed stack machine.
// No dependencies.
package tsm_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int SP_W        = IDX_W + 1;
	localparam int DEPTH_OUT_W = 7;

	localparam logic [5:0] OP_HALT  = 6'd0;
	localparam logic [5:0] OP_NOOP  = 6'd1;
	localparam logic [5:0] OP_PUSH  = 6'd2;
	localparam logic [5:0] OP_POP   = 6'd3;
	localparam logic [5:0] OP_DUP   = 6'd4;
	localparam logic [5:0] OP_SWAP  = 6'd5;
	localparam logic [5:0] OP_ADD   = 6'd6;
	localparam logic [5:0] OP_SUB   = 6'd7;
	localparam logic [5:0] OP_MUL   = 6'd8;
	localparam logic [5:0] OP_DIV   = 6'd9;
	localparam logic [5:0] OP_MOD   = 6'd10;
	localparam logic [5:0] OP_LOAD  = 6'd11;
	localparam logic [5:0] OP_STORE = 6'd12;
	localparam logic [5:0] OP_BR    = 6'd13;
	localparam logic [5:0] OP_BRF   = 6'd14;
	localparam logic [5:0] OP_BRT   = 6'd15;
	localparam logic [5:0] OP_BEQ   = 6'd16;
	localparam logic [5:0] OP_BGE   = 6'd17;
	localparam logic [5:0] OP_BLE   = 6'd18;
	localparam logic [5:0] OP_BLT   = 6'd19;
	localparam logic [5:0] OP_BNE   = 6'd20;
	localparam logic [5:0] OP_AND   = 6'd21;
	localparam logic [5:0] OP_OR    = 6'd22;
	localparam logic [5:0] OP_XOR   = 6'd23;
	localparam logic [5:0] OP_SHL   = 6'd24;
	localparam logic [5:0] OP_SHR   = 6'd25;
	localparam logic [5:0] OP_NOT   = 6'd26;
	localparam logic [5:0] OP_LAND  = 6'd27;
	localparam logic [5:0] OP_LOR   = 6'd28;
	localparam logic [5:0] OP_NEG   = 6'd29;
	localparam logic [5:0] OP_CONV  = 6'd30;
	localparam logic [5:0] OP_EQ    = 6'd31;
	localparam logic [5:0] OP_GE    = 6'd32;
	localparam logic [5:0] OP_GT    = 6'd33;
	localparam logic [5:0] OP_LE    = 6'd34;
	localparam logic [5:0] OP_LT    = 6'd35;
	localparam logic [5:0] OP_NE    = 6'd36;

	localparam logic [3:0] TY_VOID = 4'd0;
	localparam logic [3:0] TY_I32  = 4'd3;
	localparam logic [3:0] TY_MAX  = 4'd8;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_MISMATCH = 3'd1;
	localparam logic [2:0] ERR_BADTYPE  = 3'd2;
	localparam logic [2:0] ERR_DIVZERO  = 3'd3;
	localparam logic [2:0] ERR_UNDER    = 3'd4;
	localparam logic [2:0] ERR_OVER     = 3'd5;
	localparam logic [2:0] ERR_BADOP    = 3'd6;

	localparam logic [1:0] REG_PLEN = 2'd0;

	typedef enum logic [2:0] {
		REL_EQ = 3'd0,
		REL_GE = 3'd1,
		REL_GT = 3'd2,
		REL_LE = 3'd3,
		REL_LT = 3'd4,
		REL_NE = 3'd5
	} rel_t;

	typedef enum logic [3:0] {
		CL_HALT,
		CL_NOP,
		CL_PUSH,
		CL_POP,
		CL_DUP,
		CL_SWAP,
		CL_BR,
		CL_BRZ,
		CL_UNARY,
		CL_CONV,
		CL_BIN,
		CL_BCMP,
		CL_BAD
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [5:0]  op;
		logic [3:0]  vt;
		logic [63:0] arg;
		logic [31:0] tgt;
		rel_t        rel;
	} dec_t;

	typedef struct packed {
		logic        mul;
		logic        rem;
		logic        sgn;
		logic [63:0] a;
		logic [63:0] b;
	} md_req_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_WAIT,
		BK_SWAP,
		BK_SETTLE,
		BK_OUT
	} bk_state_t;

	function automatic logic type_signed(input logic [3:0] t);
		return (t >= 4'd1) && (t <= 4'd4);
	endfunction

	function automatic logic [5:0] shift_mask(input logic [3:0] t);
		logic [5:0] m;
		unique case (t)
			4'd1, 4'd5: m = 6'd7;
			4'd2, 4'd6: m = 6'd15;
			4'd3, 4'd7: m = 6'd31;
			default:    m = 6'd63;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] canon(input logic [3:0] t, input logic [63:0] v);
		logic [63:0] r;
		unique case (t)
			4'd1:    r = {{56{v[7]}}, v[7:0]};
			4'd2:    r = {{48{v[15]}}, v[15:0]};
			4'd3:    r = {{32{v[31]}}, v[31:0]};
			4'd5:    r = {56'b0, v[7:0]};
			4'd6:    r = {48'b0, v[15:0]};
			4'd7:    r = {32'b0, v[31:0]};
			4'd4, 4'd8: r = v;
			default: r = 64'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_less(input logic sgn, input logic [63:0] a,
			input logic [63:0] b);
		return sgn ? ($signed(a) < $signed(b)) : (a < b);
	endfunction

	function automatic logic relation(input rel_t rel, input logic sgn,
			input logic [63:0] a, input logic [63:0] b);
		logic r;
		unique case (rel)
			REL_EQ:  r = (a == b);
			REL_GE:  r = !is_less(sgn, a, b);
			REL_GT:  r = is_less(sgn, b, a);
			REL_LE:  r = !is_less(sgn, b, a);
			REL_LT:  r = is_less(sgn, a, b);
			default: r = (a != b);
		endcase
		return r;
	endfunction

endpackage

// File: rtl/typed_stack_machine_execute.sv
// Top level of the typed stack-machine execution unit.
// Depends on tsm_pkg, tsm_front and tsm_back.
//
//  channel   handshake              payload
//  request   valid / ready          opcode, value_type, argument
//  result    out_valid / out_ready  next_ip, halted, top_value, top_type,
//                                   stack_depth, error_code
//  config    APB psel/penable       paddr, pwdata, prdata (program_length)
//
// Each request passes dequeue, execute, settle and output while the result
// register is free; SWAP adds a state for its second stack write, MUL waits
// on three 32x32 steps plus the done strobe, DIV/MOD on 64 divider steps
// plus the done strobe; a divide by zero skips the divider.
// The single-write stack memory and its registered reads set the base sequence.
// Reset clears stack pointer, ip, halt flag, program_length and queues.
// A two-entry queue takes requests while the back end works or the result
// waits; the result register holds until out_ready.
module typed_stack_machine_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [5:0]  opcode,
	input  logic [3:0]  value_type,
	input  logic [63:0] argument,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_ip,
	output logic        halted,
	output logic [63:0] top_value,
	output logic [3:0]  top_type,
	output logic [6:0]  stack_depth,
	output logic [2:0]  error_code,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]   plen_q;
	logic          q_valid, q_pop;
	tsm_pkg::dec_t q_data;

	// config register; the user must write it only while the unit is idle, the block does not enforce this
	assign pready = 1'b1;
	assign prdata = (paddr == tsm_pkg::REG_PLEN) ? {16'b0, plen_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= 16'd0;
		end else if (psel && penable && pwrite && pready && paddr == tsm_pkg::REG_PLEN) begin
			plen_q <= pwdata[15:0];
		end
	end

	tsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.ready      (ready),
		.opcode     (opcode),
		.value_type (value_type),
		.argument   (argument),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop)
	);

	tsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.plen       (plen_q),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_ip     (next_ip),
		.out_halted (halted),
		.out_value  (top_value),
		.out_type   (top_type),
		.out_depth  (stack_depth),
		.out_err    (error_code)
	);

endmodule

// File: rtl/tsm_front.sv
// Front end: accepts instruction requests, classifies them and queues them.
// Depends on tsm_pkg.
module tsm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             ready,
	input  logic [5:0]       opcode,
	input  logic [3:0]       value_type,
	input  logic [63:0]      argument,
	output logic             q_valid,
	output tsm_pkg::dec_t    q_data,
	input  logic             q_pop
);

	tsm_pkg::dec_t fifo_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	tsm_pkg::dec_t dec;
	logic          push;

	always_comb begin
		dec.op  = opcode;
		dec.vt  = value_type;
		dec.arg = argument;
		dec.tgt = argument[31:0] + 32'd1;
		dec.rel = tsm_pkg::REL_EQ;
		priority if (opcode == tsm_pkg::OP_HALT) begin
			dec.cls = tsm_pkg::CL_HALT;
		end else if (opcode == tsm_pkg::OP_PUSH) begin
			dec.cls = tsm_pkg::CL_PUSH;
		end else if (opcode == tsm_pkg::OP_POP) begin
			dec.cls = tsm_pkg::CL_POP;
		end else if (opcode == tsm_pkg::OP_DUP) begin
			dec.cls = tsm_pkg::CL_DUP;
		end else if (opcode == tsm_pkg::OP_SWAP) begin
			dec.cls = tsm_pkg::CL_SWAP;
		end else if (opcode == tsm_pkg::OP_BR) begin
			dec.cls = tsm_pkg::CL_BR;
		end else if (opcode == tsm_pkg::OP_BRF || opcode == tsm_pkg::OP_BRT) begin
			dec.cls = tsm_pkg::CL_BRZ;
		end else if (opcode == tsm_pkg::OP_NOT || opcode == tsm_pkg::OP_NEG) begin
			dec.cls = tsm_pkg::CL_UNARY;
		end else if (opcode == tsm_pkg::OP_CONV) begin
			dec.cls = tsm_pkg::CL_CONV;
		end else if (opcode >= tsm_pkg::OP_BEQ && opcode <= tsm_pkg::OP_BNE) begin
			dec.cls = tsm_pkg::CL_BCMP;
			unique case (opcode)
				tsm_pkg::OP_BEQ: dec.rel = tsm_pkg::REL_EQ;
				tsm_pkg::OP_BGE: dec.rel = tsm_pkg::REL_GE;
				tsm_pkg::OP_BLE: dec.rel = tsm_pkg::REL_LE;
				tsm_pkg::OP_BLT: dec.rel = tsm_pkg::REL_LT;
				default:         dec.rel = tsm_pkg::REL_NE;
			endcase
		end else if (opcode >= tsm_pkg::OP_EQ && opcode <= tsm_pkg::OP_NE) begin
			dec.cls = tsm_pkg::CL_BIN;
			dec.rel = tsm_pkg::rel_t'(3'(opcode - tsm_pkg::OP_EQ));
		end else if ((opcode >= tsm_pkg::OP_ADD && opcode <= tsm_pkg::OP_MOD) ||
				(opcode >= tsm_pkg::OP_AND && opcode <= tsm_pkg::OP_SHR) ||
				opcode == tsm_pkg::OP_LAND || opcode == tsm_pkg::OP_LOR) begin
			dec.cls = tsm_pkg::CL_BIN;
		end else if (opcode > tsm_pkg::OP_NE) begin
			dec.cls = tsm_pkg::CL_BAD;
		end else begin
			dec.cls = tsm_pkg::CL_NOP;
		end
	end

	assign ready   = (cnt_q != 2'd2);
	assign push    = valid && ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: rtl/tsm_muldiv.sv
// Shared multi-cycle multiplier (three 32x32 steps) and radix-2 divider.
// Depends on tsm_pkg.
module tsm_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tsm_pkg::md_req_t  req,
	output logic              done,
	output logic [63:0]       result
);

	logic        busy_q, fin_q, mul_q, rem_q, negq_q, negr_q;
	logic [5:0]  cnt_q;
	logic [64:0] r_q;
	logic [63:0] quo_q, dvs_q, opa_q;
	logic [31:0] mx, my;
	logic [63:0] prod, addend;
	logic [64:0] trial, diff;
	logic        ge, last;
	logic [63:0] ma, mb;

	assign ma = (req.sgn && req.a[63]) ? (64'd0 - req.a) : req.a;
	assign mb = (req.sgn && req.b[63]) ? (64'd0 - req.b) : req.b;

	assign mx     = (cnt_q == 6'd2) ? opa_q[63:32] : opa_q[31:0];
	assign my     = (cnt_q == 6'd1) ? dvs_q[63:32] : dvs_q[31:0];
	assign prod   = mx * my;
	assign addend = (cnt_q == 6'd0) ? prod : {prod[31:0], 32'b0};

	assign trial = {r_q[63:0], quo_q[63]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};
	assign last  = mul_q ? (cnt_q == 6'd2) : (cnt_q == 6'd63);

	assign done = fin_q;
	always_comb begin
		if (mul_q) begin
			result = r_q[63:0];
		end else if (rem_q) begin
			result = negr_q ? (64'd0 - r_q[63:0]) : r_q[63:0];
		end else begin
			result = negq_q ? (64'd0 - quo_q) : quo_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mul_q  <= req.mul;
			rem_q  <= req.rem;
			negq_q <= req.sgn && (req.a[63] ^ req.b[63]);
			negr_q <= req.sgn && req.a[63];
			r_q    <= 65'd0;
			quo_q  <= ma;
			opa_q  <= req.a;
			dvs_q  <= req.mul ? req.b : mb;
			cnt_q  <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (mul_q) begin
				r_q <= r_q + {1'b0, addend};
			end else begin
				r_q   <= ge ? diff : trial;
				quo_q <= {quo_q[62:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/tsm_back.sv
// Back end: stack memory, execution sequencer and result register.
// Depends on tsm_pkg and tsm_muldiv.
module tsm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [15:0]                     plen,
	input  logic                            q_valid,
	input  tsm_pkg::dec_t                   q_data,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     out_ip,
	output logic                            out_halted,
	output logic [63:0]                     out_value,
	output logic [3:0]                      out_type,
	output logic [tsm_pkg::DEPTH_OUT_W-1:0] out_depth,
	output logic [2:0]                      out_err
);

	localparam int IW = tsm_pkg::IDX_W;
	localparam int SW = tsm_pkg::SP_W;

	logic [63:0] mem_v [tsm_pkg::STACK_DEPTH];
	logic [3:0]  mem_t [tsm_pkg::STACK_DEPTH];

	tsm_pkg::bk_state_t state_q, state_d;
	tsm_pkg::dec_t      ins_q;
	logic [SW-1:0]      sp_q, sp_d, spm1, spm2;
	logic [31:0]        ip_q, ip_d;
	logic               halt_q, halt_d;
	logic [2:0]         err_q, err_d;
	logic [63:0]        ra_v_q, rb_v_q;
	logic [3:0]         ra_t_q, rb_t_q;
	logic [63:0]        sw_v_q;
	logic [3:0]         sw_t_q;
	logic [IW-1:0]      pidx_q;
	logic [3:0]         ptyp_q;
	logic               ov_q;

	logic          we, push, md_go, swap_go, load_out;
	logic [IW-1:0] widx;
	logic [63:0]   wval, pval, a, b, ar;
	logic [3:0]    wtyp, ptyp, ta, tb;
	logic          full;
	logic [5:0]    shamt;
	logic          md_done;
	logic [63:0]   md_res;
	tsm_pkg::md_req_t md_req;

	tsm_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_go),
		.req    (md_req),
		.done   (md_done),
		.result (md_res)
	);

	assign spm1 = sp_q - SW'(1);
	assign spm2 = sp_q - SW'(2);
	assign full = (sp_q == SW'(tsm_pkg::STACK_DEPTH));

	// operands: a is the deeper one for two-operand work, top otherwise
	assign b     = ra_v_q;
	assign tb    = ra_t_q;
	assign a     = (ins_q.cls == tsm_pkg::CL_BIN || ins_q.cls == tsm_pkg::CL_BCMP) ?
		rb_v_q : ra_v_q;
	assign ta    = (ins_q.cls == tsm_pkg::CL_BIN || ins_q.cls == tsm_pkg::CL_BCMP) ?
		rb_t_q : ra_t_q;
	assign shamt = b[5:0] & tsm_pkg::shift_mask(ta);

	always_comb begin
		unique case (ins_q.op)
			tsm_pkg::OP_ADD: ar = a + b;
			tsm_pkg::OP_SUB: ar = a - b;
			tsm_pkg::OP_AND: ar = a & b;
			tsm_pkg::OP_OR:  ar = a | b;
			tsm_pkg::OP_XOR: ar = a ^ b;
			tsm_pkg::OP_SHL: ar = a << shamt;
			default: ar = tsm_pkg::type_signed(ta) ? 64'($signed(a) >>> shamt) : (a >> shamt);
		endcase
	end

	always_comb begin
		state_d  = state_q;
		sp_d     = sp_q;
		ip_d     = ip_q;
		halt_d   = halt_q;
		err_d    = err_q;
		q_pop    = 1'b0;
		push     = 1'b0;
		pval     = 64'b0;
		ptyp     = tsm_pkg::TY_VOID;
		md_go    = 1'b0;
		swap_go  = 1'b0;
		load_out = 1'b0;
		we       = 1'b0;
		widx     = spm1[IW-1:0];
		wval     = 64'b0;
		wtyp     = tsm_pkg::TY_VOID;
		md_req.mul = (ins_q.op == tsm_pkg::OP_MUL);
		md_req.rem = (ins_q.op == tsm_pkg::OP_MOD);
		md_req.sgn = tsm_pkg::type_signed(ta);
		md_req.a   = a;
		md_req.b   = b;

		unique case (state_q)
			tsm_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = tsm_pkg::BK_EXEC;
				end
			end
			tsm_pkg::BK_EXEC: begin
				err_d   = tsm_pkg::ERR_OK;
				state_d = tsm_pkg::BK_SETTLE;
				if (halt_q) begin
					// halted: state stays as it is
				end else if (ip_q >= 32'(plen)) begin
					halt_d = 1'b1;
				end else begin
					ip_d = ip_q + 32'd1;
					unique case (ins_q.cls)
						tsm_pkg::CL_HALT: halt_d = 1'b1;
						tsm_pkg::CL_PUSH: begin
							if (ins_q.vt > tsm_pkg::TY_MAX) begin
								err_d = tsm_pkg::ERR_BADTYPE;
							end else if (full) begin
								err_d = tsm_pkg::ERR_OVER;
							end else begin
								sp_d = sp_q + SW'(1);
								push = 1'b1;
								ptyp = ins_q.vt;
								pval = ins_q.arg;
							end
						end
						tsm_pkg::CL_POP: begin
							if (sp_q == '0) err_d = tsm_pkg::ERR_UNDER;
							else sp_d = spm1;
						end
						tsm_pkg::CL_DUP: begin
							if (sp_q == '0) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else if (full) begin
								err_d = tsm_pkg::ERR_OVER;
							end else begin
								sp_d = sp_q + SW'(1);
								push = 1'b1;
								ptyp = ra_t_q;
								pval = ra_v_q;
							end
						end
						tsm_pkg::CL_SWAP: begin
							if (sp_q < SW'(2)) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else begin
								// top goes one down now, the lower one goes up next cycle
								we      = 1'b1;
								widx    = spm2[IW-1:0];
								wval    = ra_v_q;
								wtyp    = ra_t_q;
								swap_go = 1'b1;
								state_d = tsm_pkg::BK_SWAP;
							end
						end
						tsm_pkg::CL_BR: ip_d = ins_q.tgt;
						tsm_pkg::CL_BRZ: begin
							if (sp_q == '0) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else begin
								sp_d = spm1;
								if ((a == 64'd0) == (ins_q.op == tsm_pkg::OP_BRF)) ip_d = ins_q.tgt;
							end
						end
						tsm_pkg::CL_UNARY: begin
							if (sp_q == '0) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else begin
								push = 1'b1;
								if (ta == tsm_pkg::TY_VOID) begin
									err_d = tsm_pkg::ERR_BADTYPE;
									ptyp  = tsm_pkg::TY_I32;
								end else if (ins_q.op == tsm_pkg::OP_NOT) begin
									ptyp = ta;
									pval = ~a;
								end else begin
									ptyp = tsm_pkg::TY_I32;
									pval = {63'b0, a == 64'd0};
								end
							end
						end
						tsm_pkg::CL_CONV: begin
							if (sp_q == '0) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else begin
								push = 1'b1;
								if (ins_q.vt == tsm_pkg::TY_VOID || ins_q.vt > tsm_pkg::TY_MAX) begin
									err_d = tsm_pkg::ERR_BADTYPE;
								end else begin
									ptyp = ins_q.vt;
									pval = a;
								end
							end
						end
						tsm_pkg::CL_BIN, tsm_pkg::CL_BCMP: begin
							if (sp_q < SW'(2)) begin
								err_d = tsm_pkg::ERR_UNDER;
							end else begin
								sp_d = spm2;
								if (ta != tb) begin
									err_d = tsm_pkg::ERR_MISMATCH;
								end else if (ins_q.cls == tsm_pkg::CL_BCMP) begin
									if (ta == tsm_pkg::TY_VOID) err_d = tsm_pkg::ERR_BADTYPE;
									else if (tsm_pkg::relation(ins_q.rel, tsm_pkg::type_signed(ta), a, b))
										ip_d = ins_q.tgt;
								end else begin
									sp_d = spm1;
									push = 1'b1;
									if (ta == tsm_pkg::TY_VOID) begin
										err_d = tsm_pkg::ERR_BADTYPE;
										ptyp  = (ins_q.op <= tsm_pkg::OP_MOD) ?
											tsm_pkg::TY_VOID : tsm_pkg::TY_I32;
									end else if (ins_q.op == tsm_pkg::OP_MUL) begin
										push    = 1'b0;
										md_go   = 1'b1;
										ptyp    = ta;
										state_d = tsm_pkg::BK_WAIT;
									end else if (ins_q.op == tsm_pkg::OP_DIV ||
											ins_q.op == tsm_pkg::OP_MOD) begin
										ptyp = ta;
										if (b == 64'd0) begin
											err_d = tsm_pkg::ERR_DIVZERO;
										end else begin
											push    = 1'b0;
											md_go   = 1'b1;
											state_d = tsm_pkg::BK_WAIT;
										end
									end else if (ins_q.op == tsm_pkg::OP_LAND) begin
										ptyp = tsm_pkg::TY_I32;
										pval = {63'b0, (a != 64'd0) && (b != 64'd0)};
									end else if (ins_q.op == tsm_pkg::OP_LOR) begin
										ptyp = tsm_pkg::TY_I32;
										pval = {63'b0, (a != 64'd0) || (b != 64'd0)};
									end else if (ins_q.op >= tsm_pkg::OP_EQ) begin
										ptyp = tsm_pkg::TY_I32;
										pval = {63'b0, tsm_pkg::relation(ins_q.rel,
											tsm_pkg::type_signed(ta), a, b)};
									end else begin
										ptyp = ta;
										pval = ar;
									end
								end
							end
						end
						tsm_pkg::CL_BAD: err_d = tsm_pkg::ERR_BADOP;
						default: ;
					endcase
					if (push) begin
						we   = 1'b1;
						widx = IW'(sp_d - SW'(1));
						wval = tsm_pkg::canon(ptyp, pval);
						wtyp = ptyp;
					end
				end
			end
			tsm_pkg::BK_WAIT: begin
				if (md_done) begin
					we      = 1'b1;
					widx    = pidx_q;
					wval    = tsm_pkg::canon(ptyp_q, md_res);
					wtyp    = ptyp_q;
					state_d = tsm_pkg::BK_SETTLE;
				end
			end
			tsm_pkg::BK_SWAP: begin
				we      = 1'b1;
				widx    = spm1[IW-1:0];
				wval    = sw_v_q;
				wtyp    = sw_t_q;
				state_d = tsm_pkg::BK_SETTLE;
			end
			tsm_pkg::BK_SETTLE: state_d = tsm_pkg::BK_OUT;
			tsm_pkg::BK_OUT: begin
				if (!ov_q || out_ready) begin
					load_out = 1'b1;
					state_d  = tsm_pkg::BK_IDLE;
				end
			end
			default: state_d = tsm_pkg::BK_IDLE;
		endcase
	end

	// stack memory: one write port, two registered read ports at the top
	always_ff @(posedge clk) begin
		if (we) begin
			mem_v[widx] <= wval;
			mem_t[widx] <= wtyp;
		end
		ra_v_q <= mem_v[spm1[IW-1:0]];
		ra_t_q <= mem_t[spm1[IW-1:0]];
		rb_v_q <= mem_v[spm2[IW-1:0]];
		rb_t_q <= mem_t[spm2[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ins_q <= q_data;
		end
		if (swap_go) begin
			sw_v_q <= rb_v_q;
			sw_t_q <= rb_t_q;
		end
		if (md_go) begin
			pidx_q <= spm2[IW-1:0];
			ptyp_q <= ptyp;
		end
		if (load_out) begin
			out_ip     <= ip_q;
			out_halted <= halt_q;
			out_value  <= (sp_q == '0) ? 64'd0 : ra_v_q;
			out_type   <= (sp_q == '0) ? tsm_pkg::TY_VOID : ra_t_q;
			out_depth  <= tsm_pkg::DEPTH_OUT_W'(sp_q);
			out_err    <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsm_pkg::BK_IDLE;
			sp_q    <= '0;
			ip_q    <= 32'd0;
			halt_q  <= 1'b0;
			err_q   <= tsm_pkg::ERR_OK;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			ip_q    <= ip_d;
			halt_q  <= halt_d;
			err_q   <= err_d;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

endmodule

// File: rtl/tsm_checker.sv
// Port-level checks of the typed stack machine, bound to the top level.
// Depends on typed_stack_machine_execute_defines.svh and tsm_pkg.
`include "typed_stack_machine_execute_defines.svh"

module tsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        halted,
	input logic [63:0] top_value,
	input logic [3:0]  top_type,
	input logic [6:0]  stack_depth,
	input logic [2:0]  error_code
);

	`TSM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TSM_ASSERT_IMP(a_halt_clean, clk, arst_n, out_valid && halted, error_code == tsm_pkg::ERR_OK, "halted result carries an error")
	`TSM_ASSERT_IMP(a_empty_top, clk, arst_n, out_valid && stack_depth == 7'd0, top_value == 64'd0 && top_type == tsm_pkg::TY_VOID, "empty stack shows a top")
	`TSM_ASSERT_IMP(a_depth_max, clk, arst_n, out_valid, stack_depth <= 7'(tsm_pkg::STACK_DEPTH) && error_code <= tsm_pkg::ERR_BADOP, "depth or error code out of range")

endmodule

bind typed_stack_machine_execute tsm_checker u_tsm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.halted      (halted),
	.top_value   (top_value),
	.top_type    (top_type),
	.stack_depth (stack_depth),
	.error_code  (error_code)
);

// File: sim/tb_top.sv
// Self-checking testbench for typed_stack_machine_execute.
// Depends on tsm_pkg and the RTL top level; checks each result against a predictor or typed row.
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 500;

	typedef struct packed {
		logic [31:0] ip;
		logic        halted;
		logic [63:0] top;
		logic [3:0]  ty;
		logic [6:0]  depth;
		logic [2:0]  err;
	} result_t;

	typedef struct packed {
		logic [5:0]  op;
		logic [3:0]  vt;
		logic [63:0] arg;
		logic        typed;  // expectation written out below
		result_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        ready;
	logic [5:0]  opcode = '0;
	logic [3:0]  value_type = '0;
	logic [63:0] argument = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] next_ip;
	logic        halted;
	logic [63:0] top_value;
	logic [3:0]  top_type;
	logic [6:0]  stack_depth;
	logic [2:0]  error_code;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	typed_stack_machine_execute u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the machine: stack, pointers and program length.
	logic [63:0] mem_val [tsm_pkg::STACK_DEPTH];
	logic [3:0]  mem_ty [tsm_pkg::STACK_DEPTH];
	int          sp = 0;
	logic [31:0] ip = '0;
	logic        hf = 1'b0;
	logic [15:0] plen = '0;

	result_t     pending_q[$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_rx = 0;
	int          cycles = 0;
	int          burst = 0;

	// ---------------------------------------------------------------
	// Type helpers
	// ---------------------------------------------------------------
	function automatic int width_of(logic [3:0] t);
		case (t)
			4'd1, 4'd5: return 8;
			4'd2, 4'd6: return 16;
			4'd3, 4'd7: return 32;
			default:    return 64;
		endcase
	endfunction

	function automatic logic is_sgn(logic [3:0] t);
		return t >= 4'd1 && t <= 4'd4;
	endfunction

	// wrap a raw value to the width of its type and extend it back to 64 bits
	function automatic logic [63:0] fit(logic [3:0] t, logic [63:0] v);
		int w;
		logic [63:0] m;
		if (t == tsm_pkg::TY_VOID || t > tsm_pkg::TY_MAX)
			return '0;
		w = width_of(t);
		if (w == 64)
			return v;
		m = (64'd1 << w) - 64'd1;
		v &= m;
		if (is_sgn(t) && v[w-1])
			v |= ~m;
		return v;
	endfunction

	function automatic logic lt(logic [3:0] t, logic [63:0] a, logic [63:0] b);
		return is_sgn(t) ? ($signed(a) < $signed(b)) : (a < b);
	endfunction

	function automatic logic holds(tsm_pkg::rel_t r, logic [3:0] t, logic [63:0] a,
			logic [63:0] b);
		case (r)
			tsm_pkg::REL_EQ: return a == b;
			tsm_pkg::REL_GE: return !lt(t, a, b);
			tsm_pkg::REL_GT: return lt(t, b, a);
			tsm_pkg::REL_LE: return !lt(t, b, a);
			tsm_pkg::REL_LT: return lt(t, a, b);
			default:         return a != b;
		endcase
	endfunction

	// signed division by magnitudes, so MIN / -1 wraps back to MIN
	function automatic logic [63:0] quot_rem(logic [3:0] t, logic [63:0] a, logic [63:0] b,
			logic want_rem);
		logic na, nb;
		logic [63:0] ma, mb, q, r;
		if (!is_sgn(t))
			return want_rem ? a % b : a / b;
		na = a[63];
		nb = b[63];
		ma = na ? -a : a;
		mb = nb ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (na != nb) q = -q;
		if (na) r = -r;
		return want_rem ? r : q;
	endfunction

	function automatic void stack_push(logic [3:0] t, logic [63:0] v);
		mem_val[sp] = fit(t, v);
		mem_ty[sp] = t;
		sp++;
	endfunction

	function automatic void stack_pop(output logic [3:0] t, output logic [63:0] v);
		sp--;
		t = mem_ty[sp];
		v = mem_val[sp];
	endfunction

	// ---------------------------------------------------------------
	// Executes one instruction on the mirror and returns the state seen after it.
	// ---------------------------------------------------------------
	function automatic result_t execute(logic [5:0] op, logic [3:0] vt, logic [63:0] arg);
		result_t     res;
		logic [2:0]  err;
		logic [31:0] nxt;
		logic [31:0] jump;
		logic [3:0]  ta, tb;
		logic [63:0] a, b, r;
		int          n;
		err = tsm_pkg::ERR_OK;
		jump = arg[31:0] + 32'd1;
		if (!hf) begin
			if (ip >= {16'd0, plen}) begin
				hf = 1'b1;
			end else begin
				nxt = ip + 32'd1;
				case (op)
					tsm_pkg::OP_HALT: hf = 1'b1;
					tsm_pkg::OP_NOOP, tsm_pkg::OP_LOAD, tsm_pkg::OP_STORE: ;
					tsm_pkg::OP_PUSH: begin
						if (vt > tsm_pkg::TY_MAX) err = tsm_pkg::ERR_BADTYPE;
						else if (sp >= tsm_pkg::STACK_DEPTH) err = tsm_pkg::ERR_OVER;
						else stack_push(vt, arg);
					end
					tsm_pkg::OP_POP: begin
						if (sp < 1) err = tsm_pkg::ERR_UNDER;
						else stack_pop(ta, a);
					end
					tsm_pkg::OP_DUP: begin
						if (sp < 1) err = tsm_pkg::ERR_UNDER;
						else if (sp >= tsm_pkg::STACK_DEPTH) err = tsm_pkg::ERR_OVER;
						else stack_push(mem_ty[sp-1], mem_val[sp-1]);
					end
					tsm_pkg::OP_SWAP: begin
						if (sp < 2) err = tsm_pkg::ERR_UNDER;
						else begin
							stack_pop(tb, b);
							stack_pop(ta, a);
							stack_push(tb, b);
							stack_push(ta, a);
						end
					end
					tsm_pkg::OP_BR: nxt = jump;
					tsm_pkg::OP_BRF, tsm_pkg::OP_BRT: begin
						if (sp < 1) err = tsm_pkg::ERR_UNDER;
						else begin
							stack_pop(ta, a);
							if ((a == 64'd0) == (op == tsm_pkg::OP_BRF)) nxt = jump;
						end
					end
					tsm_pkg::OP_NOT, tsm_pkg::OP_NEG: begin
						if (sp < 1) err = tsm_pkg::ERR_UNDER;
						else begin
							stack_pop(ta, a);
							if (ta == tsm_pkg::TY_VOID) begin
								err = tsm_pkg::ERR_BADTYPE;
								stack_push(tsm_pkg::TY_I32, 64'd0);
							end else if (op == tsm_pkg::OP_NOT) begin
								stack_push(ta, ~a);
							end else begin
								stack_push(tsm_pkg::TY_I32, {63'd0, a == 64'd0});
							end
						end
					end
					tsm_pkg::OP_CONV: begin
						if (sp < 1) err = tsm_pkg::ERR_UNDER;
						else begin
							stack_pop(ta, a);
							if (vt == tsm_pkg::TY_VOID || vt > tsm_pkg::TY_MAX) begin
								err = tsm_pkg::ERR_BADTYPE;
								stack_push(tsm_pkg::TY_VOID, 64'd0);
							end else begin
								stack_push(vt, a);
							end
						end
					end
					default: begin
						if (op > tsm_pkg::OP_NE) err = tsm_pkg::ERR_BADOP;
						else if (sp < 2) err = tsm_pkg::ERR_UNDER;
						else begin
							stack_pop(tb, b);
							stack_pop(ta, a);
							if (ta != tb) begin
								err = tsm_pkg::ERR_MISMATCH;
							end else if (op >= tsm_pkg::OP_BEQ && op <= tsm_pkg::OP_BNE) begin
								tsm_pkg::rel_t br;
								case (op)
									tsm_pkg::OP_BEQ: br = tsm_pkg::REL_EQ;
									tsm_pkg::OP_BGE: br = tsm_pkg::REL_GE;
									tsm_pkg::OP_BLE: br = tsm_pkg::REL_LE;
									tsm_pkg::OP_BLT: br = tsm_pkg::REL_LT;
									default:         br = tsm_pkg::REL_NE;
								endcase
								if (ta == tsm_pkg::TY_VOID) err = tsm_pkg::ERR_BADTYPE;
								else if (holds(br, ta, a, b)) nxt = jump;
							end else if (ta == tsm_pkg::TY_VOID) begin
								err = tsm_pkg::ERR_BADTYPE;
								if (op <= tsm_pkg::OP_MOD) stack_push(tsm_pkg::TY_VOID, 64'd0);
								else stack_push(tsm_pkg::TY_I32, 64'd0);
							end else if (op == tsm_pkg::OP_LAND) begin
								stack_push(tsm_pkg::TY_I32, {63'd0, a != 64'd0 && b != 64'd0});
							end else if (op == tsm_pkg::OP_LOR) begin
								stack_push(tsm_pkg::TY_I32, {63'd0, a != 64'd0 || b != 64'd0});
							end else if (op >= tsm_pkg::OP_EQ) begin
								stack_push(tsm_pkg::TY_I32, {63'd0,
									holds(tsm_pkg::rel_t'(3'(op - tsm_pkg::OP_EQ)), ta, a, b)});
							end else begin
								n = int'(b & 64'(width_of(ta) - 1));
								case (op)
									tsm_pkg::OP_ADD: r = a + b;
									tsm_pkg::OP_SUB: r = a - b;
									tsm_pkg::OP_MUL: r = a * b;
									tsm_pkg::OP_DIV, tsm_pkg::OP_MOD: begin
										if (b == 64'd0) begin
											err = tsm_pkg::ERR_DIVZERO;
											r = 64'd0;
										end else begin
											r = quot_rem(ta, a, b, op == tsm_pkg::OP_MOD);
										end
									end
									tsm_pkg::OP_AND: r = a & b;
									tsm_pkg::OP_OR:  r = a | b;
									tsm_pkg::OP_XOR: r = a ^ b;
									tsm_pkg::OP_SHL: r = a << n;
									default: r = is_sgn(ta) ? 64'($signed(a) >>> n) : a >> n;
								endcase
								stack_push(ta, r);
							end
						end
					end
				endcase
				ip = nxt;
			end
		end
		res.ip = ip;
		res.halted = hf;
		res.top = sp > 0 ? mem_val[sp-1] : '0;
		res.ty = sp > 0 ? mem_ty[sp-1] : tsm_pkg::TY_VOID;
		res.depth = 7'(sp);
		res.err = err;
		return res;
	endfunction

	function automatic result_t expect_ok(logic [31:0] i, logic [63:0] top, logic [3:0] ty,
			logic [6:0] d, logic [2:0] e);
		return '{ip: i, halted: 1'b0, top: top, ty: ty, depth: d, err: e};
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------
	function automatic int sender_gap();
		if (n_sent >= 250 && n_sent < 400)
			return 0;  // long stretch with no idling
		return ($urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
	endfunction

	// offer one request, hold it until taken, then run it through the predictor
	task automatic send(logic [5:0] op, logic [3:0] vt, logic [63:0] arg,
			logic typed = 1'b0, result_t res = '0);
		int      gap;
		result_t predicted;
		gap = sender_gap();
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		opcode <= op;
		value_type <= vt;
		argument <= arg;
		do @(posedge clk); while (!ready);
		predicted = execute(op, vt, arg);
		pending_q.push_back(typed ? res : predicted);
		n_sent++;
	endtask

	task automatic write_plen(logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(tsm_pkg::REG_PLEN * 4);
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		plen = v;
	endtask

	// every result back, then room for a divide still in flight
	task automatic drain();
		valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'd1;
			2: return '1;
			3: return 64'h8000_0000_0000_0000;
			4: return 64'h7fff_ffff_ffff_ffff;
			5, 6: return 64'($urandom_range(0, 40));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_target();
		logic [63:0] t;
		t = {$urandom, 32'($urandom_range(0, 50000))};
		if ($urandom_range(0, 30) == 0)
			t[31:0] = '1;  // target + 1 wraps to address zero
		return t;
	endfunction

	// mostly well-typed programs: operands share the type on top of the stack
	task automatic random_request();
		logic [5:0]  op;
		logic [3:0]  vt;
		int          r;
		r = $urandom_range(0, 99);
		vt = (sp > 0 && $urandom_range(0, 99) < 85) ? mem_ty[sp-1] : 4'($urandom_range(1, 8));
		if (burst == 0 && $urandom_range(0, 99) < 2)
			burst = 70;  // run the stack into its ceiling
		if (r < 8) begin
			op = 6'($urandom_range(0, 63));
			if (op == tsm_pkg::OP_HALT)
				op = tsm_pkg::OP_NOOP;
			send(op, 4'($urandom_range(0, 15)), {$urandom, $urandom});
		end else if (burst > 0) begin
			burst--;
			send($urandom_range(0, 3) == 0 ? tsm_pkg::OP_DUP : tsm_pkg::OP_PUSH, vt,
				pick_value());
		end else if (sp < 2 || r < 35) begin
			send(tsm_pkg::OP_PUSH, vt, pick_value());
		end else begin
			op = 6'($urandom_range(1, 36));
			if (op == tsm_pkg::OP_CONV)
				send(op, 4'($urandom_range(0, 9)), pick_value());
			else
				send(op, vt, pick_target());
		end
	endtask

	// ---------------------------------------------------------------
	// Directed rows; typed expectations where the value is plain to see
	// ---------------------------------------------------------------
	row_t dir_rows[$];

	initial begin
		dir_rows = '{
			'{tsm_pkg::OP_POP, 4'd0, 64'd0, 1'b1,
				expect_ok(1, 0, tsm_pkg::TY_VOID, 0, tsm_pkg::ERR_UNDER)},
			'{tsm_pkg::OP_PUSH, 4'd1, 64'h80, 1'b1,
				expect_ok(2, 64'hffff_ffff_ffff_ff80, 4'd1, 1, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_PUSH, 4'd9, 64'd7, 1'b1,
				expect_ok(3, 64'hffff_ffff_ffff_ff80, 4'd1, 1, tsm_pkg::ERR_BADTYPE)},
			'{tsm_pkg::OP_PUSH, 4'd1, '1, 1'b1, expect_ok(4, '1, 4'd1, 2, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_ADD, 4'd0, 64'd0, 1'b1,
				expect_ok(5, 64'd127, 4'd1, 1, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_PUSH, 4'd1, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_DIV, 4'd0, 64'd0, 1'b1,
				expect_ok(7, 0, 4'd1, 1, tsm_pkg::ERR_DIVZERO)},
			'{tsm_pkg::OP_PUSH, 4'd4, 64'h8000_0000_0000_0000, 1'b0, '0},
			'{tsm_pkg::OP_PUSH, 4'd4, '1, 1'b0, '0},
			// most negative divided by minus one wraps
			'{tsm_pkg::OP_DIV, 4'd0, 64'd0, 1'b1,
				expect_ok(10, 64'h8000_0000_0000_0000, 4'd4, 2, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_PUSH, 4'd5, 64'h1ff, 1'b1,
				expect_ok(11, 64'd255, 4'd5, 3, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_ADD, 4'd0, 64'd0, 1'b1,
				expect_ok(12, 0, 4'd1, 1, tsm_pkg::ERR_MISMATCH)},
			'{tsm_pkg::OP_PUSH, 4'd0, 64'd5, 1'b0, '0},
			'{tsm_pkg::OP_PUSH, 4'd0, 64'd9, 1'b0, '0},
			'{tsm_pkg::OP_ADD, 4'd0, 64'd0, 1'b1,
				expect_ok(15, 0, tsm_pkg::TY_VOID, 2, tsm_pkg::ERR_BADTYPE)},
			'{tsm_pkg::OP_NOT, 4'd0, 64'd0, 1'b1,
				expect_ok(16, 0, tsm_pkg::TY_I32, 2, tsm_pkg::ERR_BADTYPE)},
			'{tsm_pkg::OP_BR, 4'd0, 64'd99, 1'b1,
				expect_ok(100, 0, tsm_pkg::TY_I32, 2, tsm_pkg::ERR_OK)},
			'{tsm_pkg::OP_CONV, 4'd0, 64'd0, 1'b0, '0},
			'{6'd63, 4'd15, '1, 1'b1,
				expect_ok(102, 0, tsm_pkg::TY_VOID, 2, tsm_pkg::ERR_BADOP)},
			'{tsm_pkg::OP_PUSH, 4'd8, '1, 1'b0, '0},
			'{tsm_pkg::OP_DUP, 4'd0, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_PUSH, 4'd8, 64'd3, 1'b0, '0},
			'{tsm_pkg::OP_SHR, 4'd0, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_SWAP, 4'd0, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_LOAD, 4'd0, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_STORE, 4'd0, 64'd0, 1'b0, '0},
			'{tsm_pkg::OP_BNE, 4'd0, 64'hffff_ffff, 1'b0, '0}
		};
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_plen(16'hffff);  // largest program
		foreach (dir_rows[i])
			send(dir_rows[i].op, dir_rows[i].vt, dir_rows[i].arg, dir_rows[i].typed,
				dir_rows[i].res);
		for (int i = 0; i < N_RANDOM / 2; i++)
			random_request();
		drain();
		write_plen(16'd60000);
		for (int i = 0; i < N_RANDOM / 2; i++)
			random_request();
		drain();
		// end of program: either by running past the length or by HALT
		if ($urandom_range(0, 1) == 0) begin
			write_plen(16'(ip + 32'd2));
			repeat (3) send(tsm_pkg::OP_NOOP, 4'd0, 64'd0);
		end else begin
			send(tsm_pkg::OP_NOOP, 4'd0, 64'd0);
			send(tsm_pkg::OP_HALT, 4'd0, 64'd0);
		end
		repeat (5) random_request();  // ignored once halted
		drain();
		write_plen(16'd0);
		repeat (5) random_request();
		drain();
		if (errors == 0)
			$display("typed_stack_machine_execute regression: pass");
		else
			$display("typed_stack_machine_execute regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: random back-pressure, one long hold-off, field checks
	// ---------------------------------------------------------------
	initial begin : result_side
		result_t e;
		logic    stalled;
		stalled = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				n_rx++;
				if (pending_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (next_ip !== e.ip) begin
						$error("next_ip exp %0h got %0h", e.ip, next_ip); errors++;
					end
					if (halted !== e.halted) begin
						$error("halted exp %0b got %0b", e.halted, halted); errors++;
					end
					if (top_value !== e.top) begin
						$error("top_value exp %0h got %0h", e.top, top_value); errors++;
					end
					if (top_type !== e.ty) begin
						$error("top_type exp %0d got %0d", e.ty, top_type); errors++;
					end
					if (stack_depth !== e.depth) begin
						$error("stack_depth exp %0d got %0d", e.depth, stack_depth); errors++;
					end
					if (error_code !== e.err) begin
						$error("error_code exp %0d got %0d", e.err, error_code); errors++;
					end
				end
			end
			if (!stalled && n_rx >= 150) begin
				// hold off while requests keep coming, so the input queue backs up
				stalled = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				out_ready <= 1'b1;
			end else if (n_rx >= 250 && n_rx < 400) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 12);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("typed_stack_machine_execute regression: fail");
			$finish;
		end
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tsm_pkg.sv
rtl/tsm_front.sv
rtl/tsm_muldiv.sv
rtl/tsm_back.sv
rtl/typed_stack_machine_execute.sv
rtl/tsm_checker.sv
sim/tb_top.sv
